// ===== src/aes_pkg.sv =====
package aes_pkg;

  localparam int unsigned ROUNDS   = 10;
  localparam int unsigned RK_DEPTH = ROUNDS + 1;
  localparam int unsigned RK_AW    = $clog2(RK_DEPTH);
  localparam int unsigned CFG_IW   = 8;

  // operation codes
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_KEY_HI = 8'd0;
  localparam logic [CFG_IW-1:0] REG_KEY_LO = 8'd1;

  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

  localparam logic [7:0] RSBOX [0:255] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // byte i of the state, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? RSBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    return t;
  endfunction

  // byte 4c+r is row r of column c
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*(4*((c+r)%4)+r) -: 8] = get_byte(s, 4*c+r);
        end else begin
          t[127-8*(4*c+r) -: 8] = get_byte(s, 4*((c+r)%4)+r);
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   a2 [4];
    logic [7:0]   a4 [4];
    logic [7:0]   a8 [4];
    logic [7:0]   m1 [4];
    logic [7:0]   m2 [4];
    logic [7:0]   m3 [4];
    logic [7:0]   m0 [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = get_byte(s, 4*c+k);
        a2[k] = xtime(a[k]);
        a4[k] = xtime(a2[k]);
        a8[k] = xtime(a4[k]);
        if (inv) begin
          m0[k] = a8[k] ^ a4[k] ^ a2[k];   // 14
          m1[k] = a8[k] ^ a2[k] ^ a[k];    // 11
          m2[k] = a8[k] ^ a4[k] ^ a[k];    // 13
          m3[k] = a8[k] ^ a[k];            // 9
        end else begin
          m0[k] = a2[k];                   // 2
          m1[k] = a2[k] ^ a[k];            // 3
          m2[k] = a[k];
          m3[k] = a[k];
        end
      end
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
      end
    end
    return t;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_round_key(input logic [127:0] p, input logic [7:0] rc);
    logic [31:0] rot;
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    rot = {p[23:0], p[31:24]};
    t   = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]}
          ^ {rc, 24'h0};
    w0  = p[127:96] ^ t;
    w1  = p[95:64] ^ w0;
    w2  = p[63:32] ^ w1;
    w3  = p[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== src/aes_ram.sv =====
module aes_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/aes128_block_cipher.sv =====
// AES-128 encrypt/decrypt, one shared round unit reused for every round.
// once start is taken, the result strobe follows the initial key add plus
// ten rounds, one per cycle, round keys read from an 11-row key RAM.
// one word at a time; start may be taken in the strobe cycle.
// a key register write rebuilds all 11 rows of the key RAM, busy meanwhile.
// reset clears control and key registers; results cannot be stalled.
module aes128_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  aes_pkg::aes_in_t              in_i,
  output logic                          done_o,
  output aes_pkg::aes_out_t             out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aes_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXP,
    S_RUN
  } state_e;

  state_e                      state_q;
  logic [aes_pkg::RK_AW-1:0]   cnt_q;
  logic                        cmd_q;
  logic [127:0]                blk_q;
  logic [127:0]                rk_q;
  logic [7:0]                  rc_q;
  logic [63:0]                 key_hi_q;
  logic [63:0]                 key_lo_q;

  logic                        accept;
  logic                        cfg_fire;
  logic                        cfg_hit;
  logic [aes_pkg::RK_AW-1:0]   cnt_nx;
  logic [aes_pkg::RK_AW-1:0]   last_idx;
  logic [aes_pkg::RK_AW-1:0]   raddr;
  logic [127:0]                rdata;
  logic                        we;
  logic [127:0]                wdata;
  logic [127:0]                rk_new;
  logic [127:0]                rnd_out;
  logic [127:0]                t_enc;
  logic [127:0]                t_dec;
  logic                        last_rnd;

  assign last_idx    = aes_pkg::RK_AW'(aes_pkg::ROUNDS);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start_i;
  assign accept      = start_i && !busy_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = (cfg_index_i == aes_pkg::REG_KEY_HI) ||
                       (cfg_index_i == aes_pkg::REG_KEY_LO);
  assign cnt_nx      = cnt_q + 1'b1;
  assign last_rnd    = (cnt_q == last_idx);

  // round key address for the step that runs next cycle
  always_comb begin
    if (accept) begin
      raddr = (in_i.cmd == aes_pkg::CMD_DEC) ? last_idx : '0;
    end else begin
      raddr = (cmd_q == aes_pkg::CMD_DEC) ? (last_idx - cnt_nx) : cnt_nx;
    end
  end

  // key schedule, one round key per cycle
  assign rk_new = aes_pkg::next_round_key(rk_q, rc_q);
  assign we     = (state_q == S_EXP);
  assign wdata  = (cnt_q == '0) ? {key_hi_q, key_lo_q} : rk_new;

  aes_ram #(
    .Width (128),
    .Depth (aes_pkg::RK_DEPTH)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared round unit
  always_comb begin
    t_enc = aes_pkg::shift_rows(aes_pkg::sub_bytes(blk_q, 1'b0), 1'b0);
    if (!last_rnd) begin
      t_enc = aes_pkg::mix_columns(t_enc, 1'b0);
    end
    t_enc = t_enc ^ rdata;
    t_dec = aes_pkg::sub_bytes(aes_pkg::shift_rows(blk_q, 1'b1), 1'b1) ^ rdata;
    if (!last_rnd) begin
      t_dec = aes_pkg::mix_columns(t_dec, 1'b1);
    end
    if (cnt_q == '0) begin
      rnd_out = blk_q ^ rdata;
    end else if (cmd_q == aes_pkg::CMD_DEC) begin
      rnd_out = t_dec;
    end else begin
      rnd_out = t_enc;
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_o   <= 1'b0;
      key_hi_q <= '0;
      key_lo_q <= '0;
      rc_q     <= aes_pkg::RCON_INIT;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_fire && cfg_hit) begin
            if (cfg_index_i == aes_pkg::REG_KEY_HI) begin
              key_hi_q <= cfg_data_i;
            end else begin
              key_lo_q <= cfg_data_i;
            end
            cnt_q   <= '0;
            state_q <= S_EXP;
          end else if (accept) begin
            cmd_q   <= in_i.cmd;
            blk_q   <= {in_i.block_hi, in_i.block_lo};
            cnt_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_EXP: begin
          if (cnt_q == '0) begin
            rk_q <= {key_hi_q, key_lo_q};
            rc_q <= aes_pkg::RCON_INIT;
          end else begin
            rk_q <= rk_new;
            rc_q <= aes_pkg::xtime(rc_q);
          end
          cnt_q <= cnt_nx;
          if (last_rnd) begin
            state_q <= S_IDLE;
          end
        end
        S_RUN: begin
          blk_q <= rnd_out;
          cnt_q <= cnt_nx;
          if (last_rnd) begin
            out_o   <= {rnd_out[127:64], rnd_out[63:0]};
            done_o  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/aes128_block_cipher_chk.sv =====
module aes128_block_cipher_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  // a taken word must be followed by its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##12 done_o)
    else $error("result strobe not 12 cycles after start");

  // no result strobe without work in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe while idle");

  // strobe lasts one cycle
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // a key write is taken only while idle
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && !start_i |-> !busy_o)
    else $error("key write taken while busy");

endmodule

bind aes128_block_cipher aes128_block_cipher_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned                   WATCHDOG_LIMIT = 4000;
  localparam int unsigned                   SETTLE_CYCLES  = 16;
  localparam logic [aes_pkg::CFG_IW-1:0]    REG_UNUSED     = 8'hFF;
  localparam logic [7:0]                    AFFINE_CONST   = 8'h63;
  localparam logic [7:0]                    GF_POLY        = 8'h1B;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  aes_pkg::aes_in_t           in_i = '0;
  logic                       done_o;
  aes_pkg::aes_out_t          out_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [aes_pkg::CFG_IW-1:0] cfg_index_i = '0;
  logic [63:0]                cfg_data_i = '0;

  aes128_block_cipher uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // blocks waiting to be sent, and cipher outputs still owed by the block
  aes_pkg::aes_in_t  block_q [$];
  aes_pkg::aes_out_t cipher_q [$];
  int unsigned idle_pct = 0;
  logic        hold_off = 1'b0;
  logic        word_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // predictor state: key registers, key schedule, substitution tables
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  logic [31:0] sched_w [44];
  logic [7:0]  sub_fwd [256];
  logic [7:0]  sub_inv [256];

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc ^= x;
      x = gf_dbl(x);
    end
    return acc;
  endfunction

  // s-box from the field inverse and the affine map
  function automatic void build_sbox();
    logic [7:0] iv;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      iv = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_prod(8'(x), 8'(y)) == 8'h01) iv = 8'(y);
      end
      b = iv ^ {iv[6:0], iv[7]} ^ {iv[5:0], iv[7:6]} ^ {iv[4:0], iv[7:5]}
          ^ {iv[3:0], iv[7:4]} ^ AFFINE_CONST;
      sub_fwd[x] = b;
      sub_inv[b] = 8'(x);
    end
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched_w[0] = key_hi_q[63:32];
    sched_w[1] = key_hi_q[31:0];
    sched_w[2] = key_lo_q[63:32];
    sched_w[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched_w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_fwd[t[31:24]], sub_fwd[t[23:16]], sub_fwd[t[15:8]], sub_fwd[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end
      sched_w[i] = sched_w[i-4] ^ t;
    end
  endfunction

  // full cipher on one block, byte 4c+r is row r of column c
  function automatic aes_pkg::aes_out_t cipher_block(input aes_pkg::aes_in_t w);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   m [4];
    logic [7:0]   v;
    logic [127:0] blk;
    logic         dec;
    int           rnd;
    dec = (w.cmd == aes_pkg::CMD_DEC);
    blk = {w.block_hi, w.block_lo};
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (dec) begin
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int step = 0; step <= aes_pkg::ROUNDS; step++) begin
      rnd = dec ? aes_pkg::ROUNDS - step : step;
      if (step > 0) begin
        // shift rows then substitute (order does not matter bytewise)
        t = s;
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            if (dec) s[4*((c+r)%4)+r] = sub_inv[t[4*c+r]];
            else     s[4*c+r] = sub_fwd[t[4*((c+r)%4)+r]];
          end
        end
        // forward mix comes before the key add
        if (!dec && step < aes_pkg::ROUNDS) begin
          t = s;
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
              v = '0;
              for (int k = 0; k < 4; k++) v ^= gf_prod(t[4*c+k], m[(k-r+4)%4]);
              s[4*c+r] = v;
            end
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) s[4*c+r] ^= sched_w[4*rnd+c][31-8*r -: 8];
      end
      // inverse mix follows the key add
      if (dec && step > 0 && step < aes_pkg::ROUNDS) begin
        t = s;
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            v = '0;
            for (int k = 0; k < 4; k++) v ^= gf_prod(t[4*c+k], m[(k-r+4)%4]);
            s[4*c+r] = v;
          end
        end
      end
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    return '{result_hi: blk[127:64], result_lo: blk[63:0]};
  endfunction

  // driver: one block word per handshake, random gaps
  always @(negedge clk_i) begin
    if (start_i && !word_taken) begin
      start_i <= 1'b1;
    end else if (block_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
      start_i <= 1'b1;
      in_i    <= block_q.pop_front();
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: predict on accept, check on strobe, watchdog
  always @(posedge clk_i) begin
    aes_pkg::aes_out_t want;
    word_taken <= start_i && !busy_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == aes_pkg::REG_KEY_HI) key_hi_q = cfg_data_i;
        if (cfg_index_i == aes_pkg::REG_KEY_LO) key_lo_q = cfg_data_i;
        if (cfg_index_i == aes_pkg::REG_KEY_HI || cfg_index_i == aes_pkg::REG_KEY_LO)
          expand_schedule();
      end
      if (start_i && !busy_o) cipher_q.push_back(cipher_block(in_i));
      if (done_o) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", out_o);
        end else begin
          want = cipher_q.pop_front();
          if (out_o.result_hi !== want.result_hi || out_o.result_lo !== want.result_lo) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hi %h lo %h, got hi %h lo %h", want.result_hi,
                       want.result_lo, out_o.result_hi, out_o.result_lo);
          end
        end
      end
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [aes_pkg::CFG_IW-1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (block_q.size() > 0 || start_i || cipher_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_block(input logic c, input logic [63:0] hi, input logic [63:0] lo);
    block_q.push_back('{cmd: c, block_hi: hi, block_lo: lo});
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) push_block(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin
    build_sbox();
    expand_schedule();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // known-answer vector and field extremes
    write_reg(aes_pkg::REG_KEY_HI, 64'h0001020304050607);
    write_reg(aes_pkg::REG_KEY_LO, 64'h08090a0b0c0d0e0f);
    push_block(aes_pkg::CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    push_block(aes_pkg::CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    push_block(aes_pkg::CMD_ENC, '0, '0);
    push_block(aes_pkg::CMD_DEC, '0, '0);
    push_block(aes_pkg::CMD_ENC, '1, '1);
    push_block(aes_pkg::CMD_DEC, '1, '1);
    push_block(aes_pkg::CMD_ENC, {16{4'ha}}, {16{4'h5}});
    push_block(aes_pkg::CMD_DEC, {16{4'h5}}, {16{4'ha}});
    push_block(aes_pkg::CMD_ENC, 64'h8000000000000000, 64'h0000000000000001);
    push_block(aes_pkg::CMD_DEC, 64'h0000000000000001, 64'h8000000000000000);
    wait_idle();

    // phase one: random key, sender idles often, one full pause midway
    idle_pct = 22;
    write_reg(aes_pkg::REG_KEY_HI, {$urandom, $urandom});
    write_reg(aes_pkg::REG_KEY_LO, {$urandom, $urandom});
    push_random(80);
    while (block_q.size() > 0) @(posedge clk_i);
    hold_off = 1'b1;
    while (start_i || cipher_q.size() > 0) @(posedge clk_i);
    hold_off = 1'b0;
    push_random(80);
    wait_idle();

    // phase two: all-ones key, unused register index ignored
    idle_pct = 62;
    write_reg(aes_pkg::REG_KEY_HI, '1);
    write_reg(aes_pkg::REG_KEY_LO, '1);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    push_random(160);
    wait_idle();

    // partial key update first, then an all-zero key
    idle_pct = 0;
    write_reg(aes_pkg::REG_KEY_LO, '0);
    push_random(20);
    wait_idle();
    write_reg(aes_pkg::REG_KEY_HI, '0);
    push_random(160);
    wait_idle();

    if (mismatches == 0 && cipher_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
